// ===== sv/dhs_pkg.sv =====
`timescale 1ns / 1ps
package dhs_pkg;

  localparam int BUCKETS    = 8;
  localparam int NUM_BOUNDS = 7;
  localparam int BIDX_W     = 3;
  localparam int CFG_AW     = 5;
  localparam logic [31:0] TOP_BOUND = 32'hffff_ffff;

  localparam logic [31:0] BOUND_RESET [NUM_BOUNDS] = '{
    32'd100, 32'd500, 32'd1000, 32'd5000, 32'd10000, 32'd50000, 32'd100000
  };

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the beat and update the statistics
    logic div_start; // start a serial division
    logic div_sel;   // 0: average, 1: median interpolation
    logic walk_clr;  // reset the cumulative walk
    logic walk_step; // add one bucket to the walk
    logic mul;       // form span * num
    logic fin;       // register the result beat
  } dhs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic walk_hit;   // cumulative count reached half
    logic walk_end;   // last bucket visited
    logic med_direct; // median known without a division
  } dhs_sts_t;

endpackage

// ===== sv/duration_histogram_stats.sv =====
`timescale 1ns / 1ps
// A 64-step serial divider forms the average and then, when interpolating, the median.
// Throughput: one beat at a time; the next input is taken after the result leaves.
// The bucket walk visits one bucket per cycle, up to eight, while the average is divided.
// Reset (rst_n, synchronous): bounds to defaults, counts, sum, minimum and maximum reset.
module duration_histogram_stats import dhs_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // duration
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [159:0] out_tdata,  // sample_count, minimum, maximum, average, median_estimate
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  dhs_cmd_t cmd;
  dhs_sts_t sts;
  logic     cfg_we;
  logic     interp_ok;

  assign cfg_pready = 1'b1;
  assign cfg_we = cfg_psel && cfg_penable && cfg_pwrite;

  dhs_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready,
    .interp_ok, .cmd, .sts
  );

  dhs_datapath u_dp (
    .clk, .rst_n, .cmd, .sts, .interp_ok, .duration(in_tdata),
    .cfg_we, .cfg_idx(cfg_paddr[4:2]), .cfg_wdata(cfg_pwdata),
    .cfg_ridx(cfg_paddr[4:2]), .cfg_rdata(cfg_prdata), .result(out_tdata)
  );

endmodule

// ===== sv/dhs_datapath.sv =====
`timescale 1ns / 1ps
module dhs_datapath import dhs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  dhs_cmd_t    cmd,
  output dhs_sts_t    sts,
  output logic        interp_ok,
  input  logic [31:0] duration,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [31:0] cfg_wdata,
  input  logic [2:0]  cfg_ridx,
  output logic [31:0] cfg_rdata,
  output logic [159:0] result
);

  logic [31:0] bound_r [NUM_BOUNDS];
  logic [31:0] cnt_r [BUCKETS];
  logic [31:0] min_r, max_r, tot_r, avg_r, med_r;
  logic [47:0] sum_r;
  logic [BIDX_W-1:0] widx_r, fidx_r;
  logic [32:0] upper_r, lower_r;
  logic [63:0] prod_r;
  logic [31:0] lo_r, hi_r;
  logic [63:0] rem_r, quo_r, dvs_r;
  logic [6:0]  dcnt_r;
  logic        dbusy_r, dsel_r;
  logic [159:0] res_r;

  function automatic logic [31:0] upper_of(input logic [BIDX_W-1:0] b,
                                           input logic [31:0] bd [NUM_BOUNDS]);
    if (int'(b) >= BUCKETS - 1) return TOP_BOUND;
    return bd[b];
  endfunction

  // Bucket choice for the incoming duration.
  logic [BIDX_W-1:0] pick;
  always_comb begin
    pick = BIDX_W'(BUCKETS - 1);
    for (int b = BUCKETS - 2; b >= 0; b--) begin
      if (bound_r[b] >= duration) pick = BIDX_W'(b);
    end
  end

  logic [31:0] half;
  assign half = tot_r >> 1;
  logic [32:0] upper_nxt;
  assign upper_nxt = upper_r + {1'b0, cnt_r[widx_r]};

  // Clamped bounds of the current walk bucket.
  logic [31:0] lo_c, hi_c, u_c, l_c;
  always_comb begin
    u_c  = upper_of(widx_r, bound_r);
    l_c  = (widx_r == '0) ? 32'd0 : upper_of(widx_r - 1'b1, bound_r);
    hi_c = (u_c < max_r) ? u_c : max_r;
    lo_c = (l_c > min_r) ? l_c : min_r;
  end

  assign sts.walk_hit   = upper_nxt >= {1'b0, half};
  assign sts.walk_end   = (int'(widx_r) == BUCKETS - 1);
  assign sts.med_direct = (tot_r <= 32'd2);
  assign sts.div_done   = dbusy_r && (dcnt_r == 7'd0);

  logic [32:0] num_c;
  logic [31:0] den_c;
  assign den_c = cnt_r[fidx_r];
  always_comb begin
    num_c = {1'b0, half} - lower_r;
    if (num_c > {1'b0, den_c}) num_c = {1'b0, den_c};
  end

  // Interpolation only over a non-empty clamped interval with samples in it.
  assign interp_ok = (lo_r <= hi_r) && (den_c != 32'd0);

  logic [64:0] trial;
  assign trial = {rem_r, quo_r[63]} - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BOUNDS; i++) bound_r[i] <= BOUND_RESET[i];
      for (int i = 0; i < BUCKETS; i++) cnt_r[i] <= '0;
      min_r <= '1; max_r <= '0; sum_r <= '0; tot_r <= '0;
      dbusy_r <= 1'b0; dcnt_r <= '0;
    end else begin
      if (cfg_we && int'(cfg_idx) < NUM_BOUNDS) bound_r[cfg_idx] <= cfg_wdata;
      // Statistics update on a new beat.
      if (cmd.load) begin
        cnt_r[pick] <= cnt_r[pick] + 32'd1;
        if (duration > max_r) max_r <= duration;
        if (duration < min_r) min_r <= duration;
        sum_r <= sum_r + {16'd0, duration};
        tot_r <= tot_r + 32'd1;
      end
      // A finished average is stored even when the next division starts on the same edge.
      if (sts.div_done) begin
        dbusy_r <= 1'b0;
        if (!dsel_r) begin
          if (tot_r == 32'd0) avg_r <= '0;
          else avg_r <= (quo_r[63:32] != '0) ? '1 : quo_r[31:0];
        end
      end
      // Restoring divider, one quotient bit per cycle.
      if (cmd.div_start) begin
        dbusy_r <= 1'b1;
        dcnt_r  <= 7'd64;
        dsel_r  <= cmd.div_sel;
        rem_r   <= '0;
        quo_r   <= cmd.div_sel ? prod_r : {16'd0, sum_r};
        dvs_r   <= cmd.div_sel ? {32'd0, den_c} : {32'd0, tot_r};
      end else if (dbusy_r && dcnt_r != 7'd0) begin
        dcnt_r <= dcnt_r - 7'd1;
        if (!trial[64]) begin
          rem_r <= trial[63:0];
          quo_r <= {quo_r[62:0], 1'b1};
        end else begin
          rem_r <= {rem_r[62:0], quo_r[63]};
          quo_r <= {quo_r[62:0], 1'b0};
        end
      end
    end
  end

  // Walk, interpolation setup and direct median cases.
  always_ff @(posedge clk) begin
    if (cmd.walk_clr) begin
      widx_r <= '0; upper_r <= '0; lower_r <= '0;
      if (tot_r == 32'd0) med_r <= min_r;
      else med_r <= 32'(({1'b0, min_r} + {1'b0, max_r}) >> 1);
    end
    if (cmd.walk_step) begin
      if (sts.walk_hit) begin
        fidx_r <= widx_r;
        lo_r <= lo_c; hi_r <= hi_c;
        if (lo_c > hi_c) med_r <= hi_c;
        else if (cnt_r[widx_r] == 32'd0) med_r <= lo_c;
        else med_r <= lo_c;
      end else begin
        lower_r <= upper_nxt;
        upper_r <= upper_nxt;
        if (sts.walk_end) med_r <= max_r;
        else widx_r <= widx_r + 1'b1;
      end
    end
    // Interpolated median when its division finishes.
    if (sts.div_done && dsel_r) med_r <= lo_r + quo_r[31:0];
    if (cmd.mul) prod_r <= {32'd0, hi_r - lo_r} * {31'd0, num_c};
    if (cmd.fin) res_r <= {med_r, avg_r, max_r, min_r, tot_r};
  end

  assign result    = res_r;
  assign cfg_rdata = (int'(cfg_ridx) < NUM_BOUNDS) ? bound_r[cfg_ridx] : 32'd0;

endmodule

// ===== sv/dhs_ctrl.sv =====
`timescale 1ns / 1ps
module dhs_ctrl import dhs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  logic     interp_ok,
  output dhs_cmd_t cmd,
  input  dhs_sts_t sts
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001, S_AVG  = 8'b0000_0010, S_WALK = 8'b0000_0100,
    S_MUL  = 8'b0000_1000, S_DIVS = 8'b0001_0000, S_MED  = 8'b0010_0000,
    S_FIN  = 8'b0100_0000, S_OUT  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);

  // Sequencing of average division, bucket walk and median division.
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load = 1'b1;
          state_nxt = S_AVG;
        end
      end
      S_AVG: begin
        cmd.div_start = 1'b1;
        cmd.walk_clr = 1'b1;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        if (sts.med_direct) state_nxt = S_MED;
        else begin
          cmd.walk_step = 1'b1;
          if (sts.walk_hit) state_nxt = S_MUL;
          else if (sts.walk_end) state_nxt = S_MED;
        end
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_nxt = S_DIVS;
      end
      S_DIVS: begin
        if (sts.div_done) state_nxt = interp_ok ? S_MED : S_FIN;
        if (sts.div_done && interp_ok) begin
          cmd.div_start = 1'b1;
          cmd.div_sel = 1'b1;
        end
      end
      S_MED: begin
        if (sts.div_done) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == S_AVG) else $error("load did not start work");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |=> out_tvalid) else $error("result not presented");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input open while result held");

endmodule
